// ===== rtl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in this cycle implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/fqm_pkg.sv =====
// shared types, constants and helpers of the queue with largest-value tracking
`default_nettype none
package fqm_pkg;
	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef logic [CNT_W-1:0] count_t;
	typedef logic signed [31:0] word_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY_REM = 2'd1,
		ST_FULL_INS  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_REMOVE
	} cell_op_t;

	// broadcast from the control logic to every cell
	typedef struct packed {
		cell_op_t op;
		word_t    value;
		count_t   count;
	} cell_ctl_t;

	function automatic word_t max_of(input word_t a, input word_t b);
		return (a > b) ? a : b;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/fqm_cell.sv =====
// one queue cell: an entry and the largest value from it to the newest entry
`default_nettype none
module fqm_cell (
	input  wire logic              clk,
	input  wire fqm_pkg::count_t   cell_index,
	input  wire fqm_pkg::cell_ctl_t ctl,
	input  wire fqm_pkg::word_t    next_value,
	input  wire fqm_pkg::word_t    next_smax,
	output fqm_pkg::word_t         value,
	output fqm_pkg::word_t         smax
);
	import fqm_pkg::*;

	word_t value_q;
	word_t smax_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_INSERT: begin
				if (cell_index == ctl.count) begin
					value_q <= ctl.value;
					smax_q  <= ctl.value;
				end else if (cell_index < ctl.count) begin
					smax_q <= max_of(smax_q, ctl.value);
				end
			end
			OP_REMOVE: begin
				// shift toward the oldest end
				value_q <= next_value;
				smax_q  <= next_smax;
			end
			default: begin
			end
		endcase
	end

	assign value = value_q;
	assign smax  = smax_q;
endmodule
`default_nettype wire

// ===== rtl/fifo_queue_with_max.sv =====
// top level of the bounded queue with largest-value tracking
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------
//  input   | in_valid/in_stall  | command, value
//  output  | out_valid/out_stall| status, entry_count, largest, is_empty
//
// one transaction in, one transaction out; a new input is taken every cycle unless in_stall is high
// the result is registered: it is captured in the output register when the input is accepted
// each accepted input makes a single update of the cell chain
// in_stall follows out_stall while a result is waiting in the output register
// reset clears the count and out_valid; cell contents are left as they are
// and only cells below the count are ever read
`default_nettype none
`include "assert_macros.svh"
module fifo_queue_with_max (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        command,
	input  wire logic signed [31:0] value,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [4:0]       entry_count,
	output logic signed [31:0] largest,
	output logic             is_empty
);
	import fqm_pkg::*;

	localparam count_t FULL_COUNT = count_t'(DEPTH);

	// held entry count (control state)
	count_t count_q;

	// output register
	logic    out_valid_q;
	status_t status_q;
	logic [4:0] entry_count_q;
	word_t   largest_q;
	logic    is_empty_q;

	// cell chain taps; the slot past the last cell feeds zeros on a shift
	word_t chain_value [DEPTH+1];
	word_t chain_smax  [DEPTH+1];

	cell_ctl_t ctl;
	logic      accept;
	logic      is_insert;
	count_t    next_count;
	status_t   next_status;
	word_t     next_largest;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign is_insert = (command == 1'b0);

	// decide the operation and the result of this transaction
	always_comb begin
		next_count   = count_q;
		next_status  = ST_OK;
		next_largest = '0;
		ctl.op       = OP_HOLD;
		ctl.value    = value;
		ctl.count    = count_q;
		if (is_insert) begin
			if (count_q == FULL_COUNT) begin
				next_status  = ST_FULL_INS;
				next_largest = chain_smax[0];
			end else begin
				ctl.op       = accept ? OP_INSERT : OP_HOLD;
				next_count   = count_q + count_t'(1);
				next_largest = (count_q == '0) ? value : max_of(chain_smax[0], value);
			end
		end else begin
			if (count_q == '0) begin
				next_status = ST_EMPTY_REM;
			end else begin
				ctl.op     = accept ? OP_REMOVE : OP_HOLD;
				next_count = count_q - count_t'(1);
				// the second-oldest cell already holds the largest of what remains
				next_largest = (count_q == count_t'(1)) ? '0 : chain_smax[1];
			end
		end
	end

	assign chain_value[DEPTH] = '0;
	assign chain_smax[DEPTH]  = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		fqm_cell u_cell (
			.clk        (clk),
			.cell_index (count_t'(i)),
			.ctl        (ctl),
			.next_value (chain_value[i+1]),
			.next_smax  (chain_smax[i+1]),
			.value      (chain_value[i]),
			.smax       (chain_smax[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= next_count;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q      <= next_status;
			entry_count_q <= 5'(next_count);
			largest_q     <= next_largest;
			is_empty_q    <= (next_count == '0);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign entry_count = entry_count_q;
	assign largest     = largest_q;
	assign is_empty    = is_empty_q;

	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= FULL_COUNT, "count above depth")
	`ASSERT_ALWAYS(a_empty_zero, clk, arst_n,
		!(out_valid_q && is_empty_q) || (largest_q == '0),
		"empty result with nonzero largest")
	`ASSERT_ALWAYS(a_head_max, clk, arst_n,
		(count_q == '0) || (chain_smax[0] >= chain_value[0]),
		"oldest entry above the largest")
	`ASSERT_NEXT(a_remove_empty, clk, arst_n,
		accept && !is_insert && (count_q == '0),
		(status_q == ST_EMPTY_REM) && (count_q == '0),
		"remove on empty not refused")
	`ASSERT_NEXT(a_insert_count, clk, arst_n,
		accept && is_insert && (count_q != FULL_COUNT),
		count_q == $past(count_q) + count_t'(1),
		"insert did not grow count")
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// testbench for the bounded queue with largest-value tracking
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import fqm_pkg::*;

	// command encoding on the input channel
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	localparam int RANDOM_OPS  = 700;
	localparam int STALL_LIMIT = 2000;
	localparam int MAX_REPORTS = 10;
	localparam int TAIL_CYCLES = 10;

	typedef struct {
		logic  cmd;
		word_t val;
	} queue_op_t;

	typedef struct {
		status_t    status;
		logic [4:0] count;
		word_t      largest;
		logic       empty;
	} queue_resp_t;

	// all block inputs start at known values
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        command = CMD_INSERT;
	word_t       value = '0;
	logic        out_stall = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic [1:0]  status;
	logic [4:0]  entry_count;
	word_t       largest;
	logic        is_empty;

	// pending input transactions and results still owed by the block
	queue_op_t   op_q[$];
	queue_resp_t expected_q[$];

	// shadow copy of the queue contents, oldest first
	word_t       held_vals[$];
	word_t       held_max = '0;

	int          total_ops = 1;
	int          ops_taken = 0;
	int          error_count = 0;
	logic        in_taken = 1'b0;

	fifo_queue_with_max dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.entry_count (entry_count),
		.largest     (largest),
		.is_empty    (is_empty)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// expected result of one transaction; updates the shadow queue
	function automatic queue_resp_t next_queue_result(input logic cmd, input word_t val);
		queue_resp_t r;
		word_t       dropped;
		r.status = ST_OK;
		if (cmd == CMD_INSERT) begin
			if (held_vals.size() >= DEPTH) begin
				r.status = ST_FULL_INS;
			end else begin
				// first entry always becomes the largest
				if (held_vals.size() == 0 || val > held_max)
					held_max = val;
				held_vals.push_back(val);
			end
		end else if (held_vals.size() == 0) begin
			r.status = ST_EMPTY_REM;
		end else begin
			dropped = held_vals.pop_front();
			if (held_vals.size() == 0) begin
				held_max = '0;
			end else if (dropped == held_max) begin
				// the largest left: rescan what remains
				held_max = held_vals[0];
				foreach (held_vals[i])
					if (held_vals[i] > held_max)
						held_max = held_vals[i];
			end
		end
		r.count = 5'(held_vals.size());
		r.largest = (held_vals.size() == 0) ? word_t'(0) : held_max;
		r.empty = (held_vals.size() == 0);
		return r;
	endfunction

	// value mix: full range, clustered small values for ties, both extremes
	function automatic word_t pick_value();
		word_t v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = word_t'($urandom);
			4, 5, 6:    v = word_t'($urandom_range(0, 8)) - word_t'(4);
			7:          v = 32'sh8000_0000 + word_t'($urandom_range(0, 3));
			8:          v = 32'sh7fff_ffff - word_t'($urandom_range(0, 3));
			default:    v = word_t'(0) - word_t'($urandom_range(0, 3));
		endcase
		return v;
	endfunction

	function automatic void push_op(input logic cmd, input word_t val);
		queue_op_t op;
		op.cmd = cmd;
		op.val = val;
		op_q.push_back(op);
	endfunction

	// stimulus build, reset and end of run
	initial begin : stimulus
		int n;
		int bias;
		int run_left;
		word_t fill_val;

		// remove on an empty queue
		push_op(CMD_REMOVE, word_t'($urandom));
		// both extremes, then a tie on the largest
		push_op(CMD_INSERT, 32'sh8000_0000);
		push_op(CMD_INSERT, 32'sh7fff_ffff);
		push_op(CMD_INSERT, 32'sh7fff_ffff);
		// drop the smallest, then a largest that has a twin, then the last entry, then remove on empty again
		push_op(CMD_REMOVE, '0);
		push_op(CMD_REMOVE, '1);
		push_op(CMD_REMOVE, word_t'($urandom));
		push_op(CMD_REMOVE, '0);
		// fill to the brim, then one insert too many
		for (n = 0; n < DEPTH; n++) begin
			case (n)
				0:       fill_val = '0;
				1:       fill_val = -1;
				2:       fill_val = 1;
				default: fill_val = word_t'($urandom);
			endcase
			push_op(CMD_INSERT, fill_val);
		end
		push_op(CMD_INSERT, 32'sh7fff_ffff);

		// random walk: runs with an insert bias so the level swings between
		// empty and full and both refusals come up often
		run_left = 0;
		bias = 50;
		for (n = 0; n < RANDOM_OPS; n++) begin
			if (run_left == 0) begin
				run_left = $urandom_range(8, 40);
				case ($urandom_range(0, 3))
					0:       bias = 15;
					1:       bias = 50;
					2:       bias = 80;
					default: bias = 95;
				endcase
			end
			run_left--;
			push_op(($urandom_range(0, 99) < bias) ? CMD_INSERT : CMD_REMOVE, pick_value());
		end
		total_ops = op_q.size();

		// reset held from the start, released at a falling edge away from the rising edge
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// drain: everything sent and every result back
		while (op_q.size() != 0 || in_valid || expected_q.size() != 0)
			@(posedge clk);
		// room for a stray result to show up
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

	// driver: new values at the falling edge only
	always @(negedge clk) begin : drive
		int phase;
		int send_idle;
		int recv_idle;
		queue_op_t op;
		// idling phases: sender light and receiver heavy, swapped, then none
		phase = (ops_taken * 3) / total_ops;
		case (phase)
			0: begin
				send_idle = 27;
				recv_idle = 57;
			end
			1: begin
				send_idle = 57;
				recv_idle = 27;
			end
			default: begin
				send_idle = 0;
				recv_idle = 0;
			end
		endcase
		if (!arst_n) begin
			in_valid <= 1'b0;
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_idle);
			// a transaction on offer stays put until it is taken
			if (!in_valid || in_taken) begin
				if (op_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
					op = op_q.pop_front();
					command <= op.cmd;
					value <= op.val;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: both channels sampled at the rising edge
	always @(posedge clk) begin : check
		queue_resp_t exp_r;
		in_taken = arst_n && in_valid && !in_stall;
		if (in_taken) begin
			expected_q.push_back(next_queue_result(command, value));
			ops_taken++;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				// result with nothing owed
				error_count++;
				if (error_count <= MAX_REPORTS)
					$display("unexpected result: status %0d count %0d largest %0d empty %0b",
						status, entry_count, largest, is_empty);
			end else begin
				exp_r = expected_q.pop_front();
				if (status !== exp_r.status || entry_count !== exp_r.count ||
						largest !== exp_r.largest || is_empty !== exp_r.empty) begin
					error_count++;
					if (error_count <= MAX_REPORTS) begin
						$write("mismatch: expected status %0d count %0d largest %0d empty %0b,",
							exp_r.status, exp_r.count, exp_r.largest, exp_r.empty);
						$display(" got status %0d count %0d largest %0d empty %0b",
							status, entry_count, largest, is_empty);
					end
				end
			end
		end
	end

	// watchdog: too many cycles in a row with no transaction on either side
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_top: errors");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/fqm_pkg.sv
rtl/fqm_cell.sv
rtl/fifo_queue_with_max.sv
tb/tb_top.sv
